// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the window midpoint RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define IMWM_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define IMWM_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/imwm_pkg.sv -----
// Shared types and constants for the window midpoint block.
package imwm_pkg;

    localparam int LEN_W      = 7;   // window length register width
    localparam int CFG_IDX_W  = 2;   // config register index width
    localparam int SUM_W      = 25;  // half-tick sum width
    localparam int SPAN_A_W   = 26;  // quarter-tick span A width
    localparam int OUT_DATA_W = 104; // 101 payload bits padded to bytes
    localparam int NUM_WIN    = 3;   // short, mid, long

    // window slots in the accumulator arrays
    localparam int WIN_SHORT = 0;
    localparam int WIN_MID   = 1;
    localparam int WIN_LONG  = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN  = 2'd2;

    // register reset values
    localparam logic [LEN_W-1:0] SHORT_LEN_RST = 7'd9;
    localparam logic [LEN_W-1:0] MID_LEN_RST   = 7'd26;
    localparam logic [LEN_W-1:0] LONG_LEN_RST  = 7'd52;

    // per-cycle controls broadcast down the cell chain
    typedef struct packed {
        logic shift_en; // a new bar enters cell 0, history moves one cell down
        logic step_en;  // query registers take their next value
    } cell_ctl_t;

endpackage

// ----- rtl/imwm_cell.sv -----
// One cell of the chain: one history bar plus one query stage.
module imwm_cell #(
    parameter int PRICE_BITS = 24,
    parameter int IDX_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  imwm_pkg::cell_ctl_t                        ctl,
    input  logic [PRICE_BITS-1:0]                      hist_high_in,
    input  logic [PRICE_BITS-1:0]                      hist_low_in,
    output logic [PRICE_BITS-1:0]                      hist_high,
    output logic [PRICE_BITS-1:0]                      hist_low,
    input  logic                                       prev_valid,
    input  logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] prev_hi,
    input  logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] prev_lo,
    input  logic [imwm_pkg::NUM_WIN-1:0][IDX_W-1:0]      lim,
    input  logic [IDX_W-1:0]                           last_age,
    output logic                                       q_valid,
    output logic                                       fwd_valid,
    output logic                                       done,
    output logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] q_hi,
    output logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] q_lo
);

    localparam logic [IDX_W-1:0] MY_AGE = IDX_W'(IDX);

    logic [PRICE_BITS-1:0] hist_high_reg, hist_low_reg;
    logic                  q_valid_reg, q_valid_next;
    logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] q_hi_reg, q_hi_next;
    logic [imwm_pkg::NUM_WIN-1:0][PRICE_BITS-1:0] q_lo_reg, q_lo_next;
    logic [PRICE_BITS-1:0] src_high, src_low;

    // on a shift each cell folds in the bar entering it; for cell 0, the bar arriving this cycle
    assign src_high = ctl.shift_en ? hist_high_in : hist_high_reg;
    assign src_low  = ctl.shift_en ? hist_low_in  : hist_low_reg;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        q_hi_next    = q_hi_reg;
        q_lo_next    = q_lo_reg;
        if (ctl.step_en)
        begin
            q_valid_next = prev_valid;
            for (int w = 0; w < imwm_pkg::NUM_WIN; w++)
            begin
                q_hi_next[w] = prev_hi[w];
                q_lo_next[w] = prev_lo[w];
                if (MY_AGE <= lim[w])
                begin
                    if (src_high > prev_hi[w])
                        q_hi_next[w] = src_high;
                    if (src_low < prev_lo[w])
                        q_lo_next[w] = src_low;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            hist_high_reg <= hist_high_in;
            hist_low_reg  <= hist_low_in;
        end
        q_hi_reg <= q_hi_next;
        q_lo_reg <= q_lo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= q_valid_next;
    end

    assign hist_high = hist_high_reg;
    assign hist_low  = hist_low_reg;
    assign q_valid   = q_valid_reg;
    assign done      = q_valid_reg && (last_age == MY_AGE);
    assign fwd_valid = q_valid_reg && (last_age != MY_AGE);
    assign q_hi      = q_hi_reg;
    assign q_lo      = q_lo_reg;

endmodule

// ----- rtl/ichimoku_window_midpoints.sv -----
// Top level: rolling Ichimoku midpoints over a chain of history cells.
//
//  port group | dir | words                     | accepted when
//  -----------+-----+---------------------------+-------------------------
//  s_*        | in  | one price bar             | s_tvalid && s_tready
//  m_*        | out | one set of four sums      | m_tvalid && m_tready
//  cfg_*      | in  | one window length write   | cfg_we
//
// Flow: after acceptance the query walks the chain from cell 0 to the cell of the
//   oldest bar in the longest of the three windows, clipped to [1, MAX_WIN] and to
//   the bars seen since restart; it walks one cell of the chain per cycle, and no
//   new bar is taken until its result is retired into the output register.
// s_tready is high whenever no query is walking the chain, so a new bar can be
//   taken while the previous result still sits in the output register.
// A full output register stalls the query at its final cell.
// Reset clears the handshake state and the bar count and sets the window lengths to
//   9, 26, 52; history cells are not cleared and are never read before written.
`include "assert_macros.svh"

module ichimoku_window_midpoints #(
    parameter int MAX_WIN    = 64,
    parameter int PRICE_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // bar_high, bar_low, zero pad
    input  logic [((2*PRICE_BITS+7)/8)*8-1:0]      s_tdata,
    // restart
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tenkan_sum, kijun_sum, span_a_sum, span_b_sum, zero pad
    output logic [imwm_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  logic                                   cfg_we,
    input  logic [imwm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [imwm_pkg::LEN_W-1:0]             cfg_data
);

    localparam int IDX_W = $clog2(MAX_WIN);
    localparam int CNT_W = $clog2(MAX_WIN + 1);
    localparam int CMP_W = (CNT_W > imwm_pkg::LEN_W) ? CNT_W : imwm_pkg::LEN_W;
    localparam int FULL_W = PRICE_BITS + 2;
    localparam int NW = imwm_pkg::NUM_WIN;

    // ---------------- config registers ----------------
    logic [imwm_pkg::LEN_W-1:0] short_len_reg, mid_len_reg, long_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_len_reg <= imwm_pkg::SHORT_LEN_RST;
            mid_len_reg   <= imwm_pkg::MID_LEN_RST;
            long_len_reg  <= imwm_pkg::LONG_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imwm_pkg::REG_SHORT_LEN: short_len_reg <= cfg_data;
                imwm_pkg::REG_MID_LEN:   mid_len_reg   <= cfg_data;
                imwm_pkg::REG_LONG_LEN:  long_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- accept and window limits ----------------
    logic                  accept;
    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      bars_seen_reg, bars_next;
    logic [NW-1:0][IDX_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [NW-1:0][imwm_pkg::LEN_W-1:0] lens;
    logic [PRICE_BITS-1:0] bar_high, bar_low;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign bar_high = s_tdata[PRICE_BITS-1:0];
    assign bar_low  = s_tdata[2*PRICE_BITS-1:PRICE_BITS];

    assign lens[imwm_pkg::WIN_SHORT] = short_len_reg;
    assign lens[imwm_pkg::WIN_MID]   = mid_len_reg;
    assign lens[imwm_pkg::WIN_LONG]  = long_len_reg;

    always_comb
    begin
        logic [CMP_W-1:0] n;
        if (s_tuser)
            bars_next = CNT_W'(1);
        else if (bars_seen_reg < CNT_W'(MAX_WIN))
            bars_next = bars_seen_reg + CNT_W'(1);
        else
            bars_next = bars_seen_reg;

        last_next = '0;
        for (int w = 0; w < NW; w++)
        begin
            // zero length acts as one, over-long saturates, then clip to history
            n = CMP_W'(lens[w]);
            if (n == '0)
                n = CMP_W'(1);
            if (n > CMP_W'(MAX_WIN))
                n = CMP_W'(MAX_WIN);
            if (n > CMP_W'(bars_next))
                n = CMP_W'(bars_next);
            lim_next[w] = IDX_W'(n - CMP_W'(1));
            if (lim_next[w] > last_next)
                last_next = lim_next[w];
        end
    end

    // ---------------- cell chain ----------------
    imwm_pkg::cell_ctl_t ctl;
    logic                adv, any_done, out_free, retire;

    logic [MAX_WIN-1:0] c_qv, c_fwd, c_done, c_vin;
    logic [PRICE_BITS-1:0] c_hh [MAX_WIN];
    logic [PRICE_BITS-1:0] c_hl [MAX_WIN];
    logic [PRICE_BITS-1:0] c_hh_in [MAX_WIN];
    logic [PRICE_BITS-1:0] c_hl_in [MAX_WIN];
    logic [NW-1:0][PRICE_BITS-1:0] c_qhi [MAX_WIN];
    logic [NW-1:0][PRICE_BITS-1:0] c_qlo [MAX_WIN];
    logic [NW-1:0][PRICE_BITS-1:0] c_phi [MAX_WIN];
    logic [NW-1:0][PRICE_BITS-1:0] c_plo [MAX_WIN];

    assign any_done = |c_done;
    assign out_free = !m_tvalid || m_tready;
    assign retire   = any_done && out_free;
    // query only holds when its result has nowhere to go
    assign adv      = !any_done || out_free;

    assign ctl.shift_en = accept;
    assign ctl.step_en  = adv || accept;

    for (genvar j = 0; j < MAX_WIN; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            // new query starts from the identity: max 0, min all ones
            assign c_vin[j]   = accept;
            assign c_hh_in[j] = bar_high;
            assign c_hl_in[j] = bar_low;
            assign c_phi[j]   = '0;
            assign c_plo[j]   = '1;
        end
        else
        begin : g_link
            assign c_vin[j]   = c_fwd[j-1];
            assign c_hh_in[j] = c_hh[j-1];
            assign c_hl_in[j] = c_hl[j-1];
            assign c_phi[j]   = c_qhi[j-1];
            assign c_plo[j]   = c_qlo[j-1];
        end

        imwm_cell #(
            .PRICE_BITS(PRICE_BITS),
            .IDX_W     (IDX_W),
            .IDX       (j)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .hist_high_in(c_hh_in[j]),
            .hist_low_in (c_hl_in[j]),
            .hist_high   (c_hh[j]),
            .hist_low    (c_hl[j]),
            .prev_valid  (c_vin[j]),
            .prev_hi     (c_phi[j]),
            .prev_lo     (c_plo[j]),
            .lim         (lim_reg),
            .last_age    (last_reg),
            .q_valid     (c_qv[j]),
            .fwd_valid   (c_fwd[j]),
            .done        (c_done[j]),
            .q_hi        (c_qhi[j]),
            .q_lo        (c_qlo[j])
        );
    end

    // ---------------- result pick and sums ----------------
    logic [NW-1:0][PRICE_BITS-1:0] sel_hi, sel_lo;
    logic [FULL_W-1:0] t_full, k_full, b_full;
    logic [imwm_pkg::SUM_W-1:0]    tenkan, kijun, span_b;
    logic [imwm_pkg::SPAN_A_W-1:0] span_a;

    // only one cell holds the live query, so an and-or pick suffices
    always_comb
    begin
        sel_hi = '0;
        sel_lo = '0;
        for (int j = 0; j < MAX_WIN; j++)
        begin
            if (c_done[j])
            begin
                sel_hi = sel_hi | c_qhi[j];
                sel_lo = sel_lo | c_qlo[j];
            end
        end
    end

    assign t_full = FULL_W'(sel_hi[imwm_pkg::WIN_SHORT]) + FULL_W'(sel_lo[imwm_pkg::WIN_SHORT]);
    assign k_full = FULL_W'(sel_hi[imwm_pkg::WIN_MID])   + FULL_W'(sel_lo[imwm_pkg::WIN_MID]);
    assign b_full = FULL_W'(sel_hi[imwm_pkg::WIN_LONG])  + FULL_W'(sel_lo[imwm_pkg::WIN_LONG]);

    assign tenkan = imwm_pkg::SUM_W'(t_full);
    assign kijun  = imwm_pkg::SUM_W'(k_full);
    assign span_b = imwm_pkg::SUM_W'(b_full);
    assign span_a = imwm_pkg::SPAN_A_W'(t_full + k_full);

    // ---------------- output register ----------------
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [imwm_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (retire)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (retire)
            m_tdata_reg <= imwm_pkg::OUT_DATA_W'({span_b, span_a, kijun, tenkan});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- control registers ----------------
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (retire)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bars_seen_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            lim_reg       <= '0;
            last_reg      <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                bars_seen_reg <= bars_next;
                lim_reg       <= lim_next;
                last_reg      <= last_next;
            end
        end
    end

    // ---------------- checks ----------------
    `IMWM_CHECK_ALWAYS(a_one_query, $onehot0(c_qv), "more than one query in the chain")
    `IMWM_CHECK(a_busy_tracks_chain, busy_reg == (c_qv != '0), "busy flag disagrees with chain")
    `IMWM_CHECK(a_accept_starts_query, accept |=> c_qv[0], "accepted bar did not start a query")
    `IMWM_CHECK(a_count_bound, bars_seen_reg <= CNT_W'(MAX_WIN), "bar count above window depth")
    `IMWM_CHECK(a_limits_in_order, last_reg >= lim_reg[imwm_pkg::WIN_SHORT] && last_reg >= lim_reg[imwm_pkg::WIN_MID] && last_reg >= lim_reg[imwm_pkg::WIN_LONG], "final cell below a window limit")

endmodule
